FILE: hw/rtl/dnld_pkg.sv
// Shared types and constants for the day/night light detector.
// No dependencies; imported by every module of the block.
package dnld_pkg;

  // Fixed field widths of the item, result and register ports
  localparam int SAMPLE_W  = 10;
  localparam int ELAPSED_W = 16;
  localparam int ADDR_W    = 7;
  localparam int ROUTE_W   = 8;
  localparam int CODE_W    = 3;
  localparam int THRESH_W  = 10;
  localparam int DEBOUNCE_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Timing constants, in milliseconds
  localparam logic [31:0] START_DELAY_MS = 32'd11000;
  localparam logic [31:0] TOO_LONG_MS    = 32'd72000000;

  // Message queue depth (power of two)
  localparam int Q_DEPTH = 2;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EVENING_THRESHOLD   = 3'd0,
    REG_MORNING_THRESHOLD   = 3'd1,
    REG_EVENING_DEBOUNCE_MS = 3'd2,
    REG_MORNING_DEBOUNCE_MS = 3'd3,
    REG_TARGET_ADDRESS      = 3'd4,
    REG_STATE_ROUTE         = 3'd5,
    REG_NIGHT_WORK_ROUTE    = 3'd6,
    REG_DAY_WORK_ROUTE      = 3'd7
  } reg_idx_t;

  // Configuration register file contents
  typedef struct packed {
    logic [THRESH_W-1:0]   evening_threshold;
    logic [THRESH_W-1:0]   morning_threshold;
    logic [DEBOUNCE_W-1:0] evening_debounce_ms;
    logic [DEBOUNCE_W-1:0] morning_debounce_ms;
    logic [ADDR_W-1:0]     target_address;
    logic [ROUTE_W-1:0]    state_route;
    logic [ROUTE_W-1:0]    night_work_route;
    logic [ROUTE_W-1:0]    day_work_route;
  } cfg_t;

  // One queue entry: all notifications caused by one item (one or two)
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [ROUTE_W-1:0] route0;
    logic [CODE_W-1:0]  code0;
    logic [ROUTE_W-1:0] route1;
    logic [CODE_W-1:0]  code1;
    logic               two;
  } msg_t;

endpackage

FILE: hw/rtl/dnld_front.sv
// Front end: accepts items, runs the day/night mode machine and timer,
// and builds at most one message entry per item. Depends on dnld_pkg.
module dnld_front
  import dnld_pkg::*;
#(
  parameter int SENSOR_BITS = 10,
  parameter int TIMER_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  light_sample,
  input  logic [ELAPSED_W-1:0] elapsed_ms,
  input  logic                 poke,
  input  logic                 hold,
  input  logic                 q_ready,
  output logic                 q_push,
  output msg_t                 q_msg
);

  localparam int SB = (SENSOR_BITS < SAMPLE_W) ? SENSOR_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SB) - 64'd1);
  localparam int CW = (TIMER_BITS > 32) ? TIMER_BITS : 32;

  typedef enum logic [CODE_W-1:0] {
    M_START     = 3'd0,
    M_DAY       = 3'd1,
    M_EVE       = 3'd2,
    M_NIGHTWORK = 3'd3,
    M_NIGHT     = 3'd4,
    M_MORN      = 3'd5,
    M_DAYWORK   = 3'd6,
    M_FAIL      = 3'd7
  } mode_t;

  mode_t                 mode, mode_next;
  logic [TIMER_BITS-1:0] timer, timer_next;
  logic                  fail_reported, fail_reported_next;

  logic                  xfer;
  logic [SAMPLE_W-1:0]   sample;
  logic [TIMER_BITS:0]   sum;
  logic [TIMER_BITS-1:0] t;
  logic [CW-1:0]         tx;
  logic                  a_req, b_req, a_ok, b_ok;
  logic [ROUTE_W-1:0]    a_route;
  logic [CODE_W-1:0]     a_code;

  assign in_ready = q_ready;
  assign xfer     = in_valid & q_ready;
  assign sample   = light_sample & SAMPLE_MASK;

  // Saturating timer update
  assign sum = {1'b0, timer} + (TIMER_BITS + 1)'(elapsed_ms);
  assign t   = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
  assign tx  = CW'(t);

  // One step of the mode machine; decisions use the timer before restart
  always_comb begin
    mode_next          = mode;
    timer_next         = t;
    fail_reported_next = fail_reported;
    a_req   = 1'b0;
    a_route = cfg.state_route;
    a_code  = mode;
    b_req   = 1'b0;
    if (!hold) begin
      if (poke) begin
        a_req = 1'b1;
        if (mode == M_FAIL) begin
          mode_next          = M_START;
          fail_reported_next = 1'b0;
        end
      end else begin
        unique case (mode)
          M_START: begin
            if (tx > CW'(START_DELAY_MS)) begin
              mode_next  = (sample > cfg.evening_threshold) ? M_DAY : M_NIGHT;
              a_req      = 1'b1;
              a_code     = (sample > cfg.evening_threshold) ? M_DAY : M_NIGHT;
              timer_next = '0;
            end
          end
          M_DAY: begin
            if (sample < cfg.evening_threshold) begin
              mode_next  = M_EVE;
              a_req      = 1'b1;
              a_code     = M_EVE;
              timer_next = '0;
            end
            if (tx > CW'(TOO_LONG_MS)) begin
              mode_next          = M_FAIL;
              b_req              = 1'b1;
              fail_reported_next = 1'b0;
              timer_next         = '0;
            end
          end
          M_EVE: begin
            if (sample < cfg.evening_threshold) begin
              if (tx > CW'(cfg.evening_debounce_ms)) begin
                mode_next  = M_NIGHTWORK;
                a_req      = 1'b1;
                a_code     = M_NIGHT;
                timer_next = '0;
              end
            end else begin
              mode_next  = M_DAY;
              a_req      = 1'b1;
              a_code     = M_DAY;
              timer_next = '0;
            end
          end
          M_NIGHTWORK: begin
            mode_next = M_NIGHT;
            a_req     = 1'b1;
            a_route   = cfg.night_work_route;
            a_code    = M_NIGHTWORK;
          end
          M_NIGHT: begin
            if (sample > cfg.morning_threshold) begin
              mode_next  = M_MORN;
              a_req      = 1'b1;
              a_code     = M_MORN;
              timer_next = '0;
            end
            if (tx > CW'(TOO_LONG_MS)) begin
              mode_next          = M_FAIL;
              b_req              = 1'b1;
              fail_reported_next = 1'b0;
              timer_next         = '0;
            end
          end
          M_MORN: begin
            if (sample > cfg.morning_threshold) begin
              if (tx > CW'(cfg.morning_debounce_ms)) begin
                mode_next  = M_DAYWORK;
                a_req      = 1'b1;
                a_code     = M_DAY;
                timer_next = '0;
              end
            end else begin
              mode_next  = M_NIGHT;
              a_req      = 1'b1;
              a_code     = M_NIGHT;
              timer_next = '0;
            end
          end
          M_DAYWORK: begin
            mode_next = M_DAY;
            a_req     = 1'b1;
            a_route   = cfg.day_work_route;
            a_code    = M_DAYWORK;
          end
          M_FAIL: begin
            // fail is reported once, then latched even if messages are off
            a_req              = ~fail_reported;
            a_code             = M_FAIL;
            fail_reported_next = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Drop disabled messages and pack the survivors to the front
  assign a_ok = a_req && (cfg.target_address != '0) && (a_route != '0);
  assign b_ok = b_req && (cfg.target_address != '0) && (cfg.state_route != '0);

  always_comb begin
    q_msg.addr   = cfg.target_address;
    q_msg.route0 = a_ok ? a_route : cfg.state_route;
    q_msg.code0  = a_ok ? a_code : M_FAIL;
    q_msg.route1 = cfg.state_route;
    q_msg.code1  = M_FAIL;
    q_msg.two    = a_ok & b_ok;
  end

  assign q_push = xfer & (a_ok | b_ok);

  // Mode, timer and fail flag
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_START;
      timer         <= '0;
      fail_reported <= 1'b0;
    end else if (xfer) begin
      mode          <= mode_next;
      timer         <= timer_next;
      fail_reported <= fail_reported_next;
    end
  end

  // A held item never changes the mode
  a_hold_keeps_mode: assert property (@(posedge clk) disable iff (rst)
    xfer && hold |=> mode == $past(mode))
    else $error("mode changed on a held item");

  // A plain step in fail always leaves the flag set
  a_fail_latched: assert property (@(posedge clk) disable iff (rst)
    xfer && !hold && !poke && mode == M_FAIL |=> fail_reported)
    else $error("fail flag not set after fail step");

endmodule

FILE: hw/rtl/dnld_queue.sv
// Small flop-based queue of message entries between front and back end.
// Depends on dnld_pkg (msg_t, Q_DEPTH).
module dnld_queue
  import dnld_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  msg_t push_msg,
  output logic not_full,
  input  logic pop,
  output logic not_empty,
  output msg_t pop_msg
);

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int NW = $clog2(Q_DEPTH + 1);

  msg_t          mem [Q_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;

  assign not_full  = (count != NW'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign pop_msg   = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_msg;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      count <= count + NW'(push) - NW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(Q_DEPTH))
    else $error("queue count above depth");

endmodule

FILE: hw/rtl/dnld_back.sv
// Back end: takes message entries from the queue and sends them out one
// notification per transfer through an output register. Depends on dnld_pkg.
module dnld_back
  import dnld_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  msg_t               q_msg,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ADDR_W-1:0]  dest_address,
  output logic [ROUTE_W-1:0] dest_route,
  output logic [CODE_W-1:0]  reported_state,
  output logic               last
);

  msg_t cur;
  logic busy;
  logic beat;
  logic done;

  assign out_valid      = busy;
  assign dest_address   = cur.addr;
  assign dest_route     = beat ? cur.route1 : cur.route0;
  assign reported_state = beat ? cur.code1 : cur.code0;
  assign last           = beat | ~cur.two;

  assign done  = busy & out_ready & last;
  assign q_pop = q_valid & (~busy | done);

  // Current entry register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_msg;
    end
  end

  // Beat sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
      beat <= 1'b0;
    end else if (done) begin
      busy <= 1'b0;
      beat <= 1'b0;
    end else if (busy && out_ready) begin
      beat <= 1'b1;
    end
  end

  // The first of two notifications is always followed by the closing one
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && last)
    else $error("second notification missing");

endmodule

FILE: hw/rtl/day_night_light_detector.sv
// Day/night light detector: top level with configuration registers,
// front end, message queue and back end. Depends on dnld_pkg and submodules.
//
// Takes one light item per cycle whenever the two-entry message queue has
// room; the mode machine and saturating timer settle each item in the
// accepting cycle. Each item gives zero, one or two notifications; only items
// with at least one enter the queue, and they are sent one per transfer from
// the output register, so the sustained rate is set by the output and its
// ready. The first notification of an item passes through the queue entry
// and then the current-entry register before it is offered.
// Configuration writes take effect at the next edge.
module day_night_light_detector
  import dnld_pkg::*;
#(
  parameter int SENSOR_BITS = 10,
  parameter int TIMER_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   light_sample,
  input  logic [ELAPSED_W-1:0]  elapsed_ms,
  input  logic                  poke,
  input  logic                  hold,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     dest_address,
  output logic [ROUTE_W-1:0]    dest_route,
  output logic [CODE_W-1:0]     reported_state,
  output logic                  last
);

  cfg_t cfg;
  logic q_push, q_not_full, q_pop, q_not_empty;
  msg_t push_msg, pop_msg;

  // Configuration registers; each keeps only its own width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.evening_threshold   <= THRESH_W'(40);
      cfg.morning_threshold   <= THRESH_W'(80);
      cfg.evening_debounce_ms <= DEBOUNCE_W'(900000);
      cfg.morning_debounce_ms <= DEBOUNCE_W'(900000);
      cfg.target_address      <= '0;
      cfg.state_route         <= '0;
      cfg.night_work_route    <= '0;
      cfg.day_work_route      <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_EVENING_THRESHOLD:   cfg.evening_threshold   <= cfg_data[THRESH_W-1:0];
        REG_MORNING_THRESHOLD:   cfg.morning_threshold   <= cfg_data[THRESH_W-1:0];
        REG_EVENING_DEBOUNCE_MS: cfg.evening_debounce_ms <= cfg_data[DEBOUNCE_W-1:0];
        REG_MORNING_DEBOUNCE_MS: cfg.morning_debounce_ms <= cfg_data[DEBOUNCE_W-1:0];
        REG_TARGET_ADDRESS:      cfg.target_address      <= cfg_data[ADDR_W-1:0];
        REG_STATE_ROUTE:         cfg.state_route         <= cfg_data[ROUTE_W-1:0];
        REG_NIGHT_WORK_ROUTE:    cfg.night_work_route    <= cfg_data[ROUTE_W-1:0];
        REG_DAY_WORK_ROUTE:      cfg.day_work_route      <= cfg_data[ROUTE_W-1:0];
        default: ;
      endcase
    end
  end

  dnld_front #(
    .SENSOR_BITS (SENSOR_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .light_sample (light_sample),
    .elapsed_ms   (elapsed_ms),
    .poke         (poke),
    .hold         (hold),
    .q_ready      (q_not_full),
    .q_push       (q_push),
    .q_msg        (push_msg)
  );

  dnld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_msg  (push_msg),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_msg   (pop_msg)
  );

  dnld_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_not_empty),
    .q_msg          (pop_msg),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .dest_address   (dest_address),
    .dest_route     (dest_route),
    .reported_state (reported_state),
    .last           (last)
  );

endmodule
